[design/sddtc_pkg.sv]
// ----------------------------------------------------------------------------
// sddtc_pkg
// Types, constants and calendar helpers for the serial day/date/time converter.
// ----------------------------------------------------------------------------
package sddtc_pkg;

    localparam int YEAR_SPAN = 200;

    localparam int ALU_W = 20;

    localparam logic [11:0] EPOCH_YEAR = 12'd1900;
    localparam logic [11:0] LAST_YEAR  = 12'(1900 + YEAR_SPAN - 1);

    localparam logic [ALU_W-1:0] SECS_PER_DAY  = ALU_W'(86400);
    localparam logic [ALU_W-1:0] SECS_PER_HOUR = ALU_W'(3600);
    localparam logic [ALU_W-1:0] SECS_PER_MIN  = ALU_W'(60);
    localparam logic [ALU_W-1:0] DAYS_YEAR     = ALU_W'(365);
    localparam logic [ALU_W-1:0] DAYS_LEAP     = ALU_W'(366);

    localparam logic [3:0] MONTH_FEB      = 4'd1;
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;
    localparam logic [3:0] MONTH_DEC      = 4'd12;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [4:0]  in_day;
        logic [3:0]  in_month;
        logic [11:0] in_year;
        logic [6:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
        logic [16:0] in_days;
        logic [18:0] in_seconds;
    } t_in_item;

    typedef struct packed {
        logic [16:0] out_days;
        logic [18:0] out_seconds;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [11:0] out_year;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic        out_of_range;
    } t_out_item;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             ge;
    } t_alu_rsp;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

    function automatic logic is_leap(input logic [11:0] year);
        is_leap = (year[1:0] == 2'd0) && (year != EPOCH_YEAR);
    endfunction

    // month index 0 is January
    function automatic logic [4:0] mon_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        mon_len = len;
    endfunction

endpackage

[design/sddtc_if.sv]
// ----------------------------------------------------------------------------
// sddtc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sddtc_in_if;
    logic                valid;
    logic                ready;
    sddtc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sddtc_out_if;
    logic                 valid;
    logic                 ready;
    sddtc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/serial_day_date_time_converter.sv]
// ----------------------------------------------------------------------------
// serial_day_date_time_converter
// Date/time <-> day count since 1900-01-01 and second count.
//
//   channel  dir  handshake     payload
//   i_in     in   valid/ready   mode, date/time fields, in_days, in_seconds
//   o_out    out  valid/ready   out_days, out_seconds, decoded fields, flag
//
// The year walk through the shared ALU (one year per cycle, up to 200) sets
// the decode time. One item at a time; i_in.ready is high only while the
// sequencer is idle. Results wait in an output register, so a new item can
// start while o_out stalls. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module serial_day_date_time_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sddtc_in_if.sink      i_in,
    sddtc_out_if.source   o_out
);

    sddtc_pkg::t_seq_stat w_stat;
    sddtc_pkg::t_out_item w_res;
    sddtc_pkg::t_alu_req  w_alu_req;
    sddtc_pkg::t_alu_rsp  w_alu_rsp;

    logic                 r_out_valid;
    sddtc_pkg::t_out_item r_out_data;
    logic                 w_slot_free;
    logic                 w_load;

    assign w_slot_free = ~r_out_valid | o_out.ready;
    assign w_load      = w_stat.done & w_slot_free;

    sddtc_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    sddtc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_in.valid & w_stat.idle),
        .i_item    (i_in.data),
        .i_take    (w_slot_free),
        .o_stat    (w_stat),
        .o_res     (w_res),
        .o_alu_req (w_alu_req),
        .i_alu_rsp (w_alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_res;
        end
    end

    assign i_in.ready  = w_stat.idle;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

[design/sddtc_alu.sv]
// ----------------------------------------------------------------------------
// sddtc_alu
// Shared add/subtract unit with unsigned compare (a >= b).
// ----------------------------------------------------------------------------
module sddtc_alu (
    input  sddtc_pkg::t_alu_req i_req,
    output sddtc_pkg::t_alu_rsp o_rsp
);

    logic [sddtc_pkg::ALU_W:0] w_diff;

    assign w_diff    = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.ge  = ~w_diff[sddtc_pkg::ALU_W];
    assign o_rsp.res = i_req.sub ? w_diff[sddtc_pkg::ALU_W-1:0] : (i_req.a + i_req.b);

endmodule

[design/sddtc_seq.sv]
// ----------------------------------------------------------------------------
// sddtc_seq
// Sequencer: shift-add encode, restoring divides and year/month walk decode,
// all through the shared ALU.
// ----------------------------------------------------------------------------
module sddtc_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  sddtc_pkg::t_in_item   i_item,
    input  logic                  i_take,
    output sddtc_pkg::t_seq_stat  o_stat,
    output sddtc_pkg::t_out_item  o_res,
    output sddtc_pkg::t_alu_req   o_alu_req,
    input  sddtc_pkg::t_alu_rsp   i_alu_rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_E_YR  = 4'd1;
    localparam logic [3:0] S_E_MON = 4'd2;
    localparam logic [3:0] S_E_DAY = 4'd3;
    localparam logic [3:0] S_E_SEC = 4'd4;
    localparam logic [3:0] S_D_DAY = 4'd5;
    localparam logic [3:0] S_D_HR  = 4'd6;
    localparam logic [3:0] S_D_MIN = 4'd7;
    localparam logic [3:0] S_D_ADD = 4'd8;
    localparam logic [3:0] S_D_YR  = 4'd9;
    localparam logic [3:0] S_D_MON = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam int W = sddtc_pkg::ALU_W;

    logic [3:0]           r_state, n_state;
    logic [2:0]           r_cnt, n_cnt;
    logic [W-1:0]         r_acc, n_acc;
    logic [4:0]           r_quot, n_quot;
    logic [2:0]           r_cdays, n_cdays;
    logic [11:0]          r_year, n_year;
    logic [11:0]          r_n, n_n;
    logic [3:0]           r_mon, n_mon;
    sddtc_pkg::t_in_item  r_in, n_in;
    sddtc_pkg::t_out_item r_res, n_res;

    logic                 w_leap;
    logic [W-1:0]         w_rem;

    assign w_leap = sddtc_pkg::is_leap(r_year);
    assign w_rem  = i_alu_rsp.ge ? i_alu_rsp.res : r_acc;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_quot  = r_quot;
        n_cdays = r_cdays;
        n_year  = r_year;
        n_n     = r_n;
        n_mon   = r_mon;
        n_in    = r_in;
        n_res   = r_res;

        o_alu_req.sub = 1'b0;
        o_alu_req.a   = r_acc;
        o_alu_req.b   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_in  = i_item;
                    n_res = '0;
                    n_acc = '0;
                    n_mon = '0;
                    n_cnt = '0;
                    n_year = i_item.in_year;
                    n_n    = i_item.in_year - sddtc_pkg::EPOCH_YEAR;
                    if (i_item.in_month == 4'd0) begin
                        n_in.in_month = 4'd1;
                    end else if (i_item.in_month > sddtc_pkg::MONTH_DEC) begin
                        n_in.in_month = sddtc_pkg::MONTH_DEC;
                    end
                    if (i_item.in_day == 5'd0) begin
                        n_in.in_day = 5'd1;
                    end
                    if (i_item.mode == sddtc_pkg::MODE_DECODE) begin
                        n_acc   = W'(i_item.in_seconds);
                        n_cnt   = 3'd2;
                        n_state = S_D_DAY;
                    end else if (i_item.in_year > sddtc_pkg::EPOCH_YEAR) begin
                        n_state = S_E_YR;
                    end else begin
                        n_state = S_E_MON;
                    end
                end
            end
            S_E_YR: begin
                // 365*n + (n+3)/4 - 1
                case (r_cnt)
                    3'd0:    o_alu_req.b = W'(r_n) << 8;
                    3'd1:    o_alu_req.b = W'(r_n) << 6;
                    3'd2:    o_alu_req.b = W'(r_n) << 5;
                    3'd3:    o_alu_req.b = W'(r_n) << 3;
                    3'd4:    o_alu_req.b = W'(r_n) << 2;
                    3'd5:    o_alu_req.b = W'(r_n);
                    3'd6:    o_alu_req.b = W'((r_n + 12'd3) >> 2);
                    default: begin
                        o_alu_req.sub = 1'b1;
                        o_alu_req.b   = W'(1);
                    end
                endcase
                n_acc = i_alu_rsp.res;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = S_E_MON;
                end
            end
            S_E_MON: begin
                o_alu_req.b = W'(sddtc_pkg::mon_len(r_mon, w_leap));
                if ((r_mon + 4'd1) < r_in.in_month) begin
                    n_acc = i_alu_rsp.res;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_state = S_E_DAY;
                end
            end
            S_E_DAY: begin
                o_alu_req.b       = W'(r_in.in_day - 5'd1);
                n_res.out_days    = i_alu_rsp.res[16:0];
                n_acc             = '0;
                n_cnt             = '0;
                n_state           = S_E_SEC;
            end
            S_E_SEC: begin
                // h*(2048+1024+512+16) + m*(64-4) + s
                case (r_cnt)
                    3'd0:    o_alu_req.b = W'(r_in.in_hour) << 11;
                    3'd1:    o_alu_req.b = W'(r_in.in_hour) << 10;
                    3'd2:    o_alu_req.b = W'(r_in.in_hour) << 9;
                    3'd3:    o_alu_req.b = W'(r_in.in_hour) << 4;
                    3'd4:    o_alu_req.b = W'(r_in.in_minute) << 6;
                    3'd5:    begin
                        o_alu_req.sub = 1'b1;
                        o_alu_req.b   = W'(r_in.in_minute) << 2;
                    end
                    default: o_alu_req.b = W'(r_in.in_second);
                endcase
                n_acc = i_alu_rsp.res;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    n_res.out_seconds = i_alu_rsp.res[18:0];
                    n_state           = S_FIN;
                end
            end
            S_D_DAY: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.b   = sddtc_pkg::SECS_PER_DAY << r_cnt;
                n_acc  = w_rem;
                n_quot = {r_quot[3:0], i_alu_rsp.ge};
                if (r_cnt == 3'd0) begin
                    n_cdays = {r_quot[1:0], i_alu_rsp.ge};
                    n_cnt   = 3'd4;
                    n_state = S_D_HR;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_D_HR: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.b   = sddtc_pkg::SECS_PER_HOUR << r_cnt;
                n_acc  = w_rem;
                n_quot = {r_quot[3:0], i_alu_rsp.ge};
                if (r_cnt == 3'd0) begin
                    n_res.out_hour = {r_quot[3:0], i_alu_rsp.ge};
                    n_cnt          = 3'd5;
                    n_state        = S_D_MIN;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_D_MIN: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.b   = sddtc_pkg::SECS_PER_MIN << r_cnt;
                n_acc  = w_rem;
                n_quot = {r_quot[3:0], i_alu_rsp.ge};
                if (r_cnt == 3'd0) begin
                    n_res.out_minute = {r_quot[4:0], i_alu_rsp.ge};
                    n_res.out_second = w_rem[5:0];
                    n_acc            = W'(r_in.in_days);
                    n_state          = S_D_ADD;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_D_ADD: begin
                o_alu_req.b = W'(r_cdays);
                n_acc   = i_alu_rsp.res;
                n_year  = sddtc_pkg::EPOCH_YEAR;
                n_state = S_D_YR;
            end
            S_D_YR: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.b   = w_leap ? sddtc_pkg::DAYS_LEAP : sddtc_pkg::DAYS_YEAR;
                if (i_alu_rsp.ge) begin
                    n_acc = i_alu_rsp.res;
                    if (r_year == sddtc_pkg::LAST_YEAR) begin
                        n_res              = '0;
                        n_res.out_of_range = 1'b1;
                        n_state            = S_FIN;
                    end else begin
                        n_year = r_year + 12'd1;
                    end
                end else begin
                    n_mon   = '0;
                    n_state = S_D_MON;
                end
            end
            S_D_MON: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.b   = W'(sddtc_pkg::mon_len(r_mon, w_leap));
                if ((r_mon < sddtc_pkg::LAST_MONTH_IDX) && i_alu_rsp.ge) begin
                    n_acc = i_alu_rsp.res;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_res.out_day   = r_acc[4:0] + 5'd1;
                    n_res.out_month = r_mon + 4'd1;
                    n_res.out_year  = r_year;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_quot  <= n_quot;
        r_cdays <= n_cdays;
        r_year  <= n_year;
        r_n     <= n_n;
        r_mon   <= n_mon;
        r_in    <= n_in;
        r_res   <= n_res;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_FIN);
    assign o_res       = r_res;

endmodule

[design/sddtc_chk.sv]
// ----------------------------------------------------------------------------
// sddtc_chk
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module sddtc_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input sddtc_pkg::t_out_item i_out_data
);

    // busy after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready stayed high after a transfer");

    // no result can appear in the cycle after an item is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    a_range_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.out_of_range) |->
            (i_out_data.out_year == 12'd0 && i_out_data.out_days == 17'd0
             && i_out_data.out_hour == 5'd0 && i_out_data.out_day == 5'd0))
        else $error("out of range result carries nonzero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind serial_day_date_time_converter sddtc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
